// ===== src/hjbp_pkg.sv =====
// Shared types and opcodes for the hash join build/probe engine.
package hjbp_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_BUILD  = 2'd1,
    OP_PROBE  = 2'd2,
    OP_FINISH = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_INNER = 2'd0,
    MODE_LEFT  = 2'd1,
    MODE_RIGHT = 2'd2,
    MODE_UNDEF = 2'd3
  } join_mode_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] join_key;
    logic        key_is_null;
    logic [31:0] row_id;
  } in_item_t;

  typedef struct packed {
    logic [31:0] build_row;
    logic        build_present;
    logic [31:0] probe_row;
    logic        probe_present;
    logic        last_of_run;
    logic        overflow_seen;
  } out_item_t;

endpackage

// ===== src/hjbp_table.sv =====
// Row table memory: key, row id and null flag, one write and one registered read port.
module hjbp_table
  import hjbp_pkg::*;
#(
  parameter int unsigned DEPTH    = 64,
  parameter int unsigned KEY_BITS = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [KEY_BITS-1:0] wkey_i,
  input  logic [31:0]         wrow_i,
  input  logic                wnull_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [KEY_BITS-1:0] rkey_o,
  output logic [31:0]         rrow_o,
  output logic                rnull_o
);

  logic [KEY_BITS+32:0] mem [DEPTH];
  logic [KEY_BITS+32:0] rdata_q;

  // Synchronous write and read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wkey_i, wrow_i, wnull_i};
    end
    rdata_q <= mem[raddr_i];
  end

  assign rkey_o  = rdata_q[KEY_BITS+32:33];
  assign rrow_o  = rdata_q[32:1];
  assign rnull_o = rdata_q[0];

endmodule

// ===== src/hash_join_build_probe.sv =====
// Top level of the hash join build/probe engine: control sequencer and output register.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_item_i) carries clear, build, probe
//   and finish items. Output channel (out_valid_o/out_ready_i/out_item_o) carries
//   join results; last_of_run marks the final result of an item. The user must write
//   join_mode via cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it.
// Sequencing and throughput:
//   Clear, build and a finish outside left mode are handled in idle and emit nothing.
//   Probe and left-mode finish scan one entry per cycle, unless a stall holds the
//   scan, through the table memory's single registered read port; the final
//   result (matched or null-filled) then leaves through the output register.
//   Results leave at up to one per cycle.
// Reset:
//   Table is emptied, matched bits and the overflow flag cleared, join_mode
//   returns to inner. Stored keys and row ids keep no reset value.
// Stalls:
//   When the receiver holds out_ready_i low, the scan pauses at a hit whose
//   result cannot move on; no new item is taken until the current one is delivered.
module hash_join_build_probe
  import hjbp_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned KEY_BITS    = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 ovf_q, ovf_d;
  logic [1:0]           mode_q;
  logic [TABLE_DEPTH-1:0] matched_q, matched_d;
  logic                 probe_q, probe_d;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic                 knull_q, knull_d;
  logic [31:0]          rid_q, rid_d;
  logic [CW-1:0]        idx_q, idx_d;    // next address to read
  logic                 rv_q, rv_d;      // read data valid for entry ridx_q
  logic [AW-1:0]        ridx_q, ridx_d;
  logic                 any_q, any_d;    // some result emitted for this item
  // pending result held back until we know whether it is the last
  logic                 pend_q, pend_d;
  out_item_t            pend_item_q, pend_item_d;
  logic                 ov_q, ov_d;
  out_item_t            ov_item_q, ov_item_d;

  logic                 tbl_we;
  logic [KEY_BITS-1:0]  tbl_key;
  logic [31:0]          tbl_row;
  logic                 tbl_null;
  logic                 accept;
  logic                 out_free;
  logic                 hit;
  logic                 scan_stall;
  logic [AW-1:0]        raddr;

  assign out_free   = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && !ov_q;
  assign accept     = in_valid_i && in_ready_o;
  assign tbl_we     = accept && (in_item_i.opcode == OP_BUILD) &&
                      (count_q < CW'(TABLE_DEPTH));
  // a hit that cannot move on holds the scan
  assign scan_stall = (state_q == ST_SCAN) && rv_q && hit && pend_q && !out_free;
  // re-read the held entry so its data stays in place during a stall
  assign raddr      = scan_stall ? ridx_q : idx_q[AW-1:0];

  hjbp_table #(
    .DEPTH   (TABLE_DEPTH),
    .KEY_BITS(KEY_BITS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(count_q[AW-1:0]),
    .wkey_i (in_item_i.join_key[KEY_BITS-1:0]),
    .wrow_i (in_item_i.row_id),
    .wnull_i(in_item_i.key_is_null),
    .raddr_i(raddr),
    .rkey_o (tbl_key),
    .rrow_o (tbl_row),
    .rnull_o(tbl_null)
  );

  // Does the entry just read produce a result
  always_comb begin
    if (probe_q) begin
      hit = !knull_q && !tbl_null && (tbl_key == key_q);
    end else begin
      hit = !matched_q[ridx_q];
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    matched_d   = matched_q;
    probe_d     = probe_q;
    key_d       = key_q;
    knull_d     = knull_q;
    rid_d       = rid_q;
    idx_d       = idx_q;
    rv_d        = rv_q;
    ridx_d      = ridx_q;
    any_d       = any_q;
    pend_d      = pend_q;
    pend_item_d = pend_item_q;
    ov_d        = ov_q;
    ov_item_d   = ov_item_q;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_item_i.opcode)
            OP_CLEAR: begin
              count_d   = '0;
              matched_d = '0;
              ovf_d     = 1'b0;
            end
            OP_BUILD: begin
              if (count_q < CW'(TABLE_DEPTH)) begin
                matched_d[count_q[AW-1:0]] = 1'b0;
                count_d = count_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            default: begin
              probe_d = (in_item_i.opcode == OP_PROBE);
              key_d   = in_item_i.join_key[KEY_BITS-1:0];
              knull_d = in_item_i.key_is_null;
              rid_d   = in_item_i.row_id;
              idx_d   = '0;
              rv_d    = 1'b0;
              any_d   = 1'b0;
              pend_d  = 1'b0;
              if (in_item_i.opcode == OP_FINISH && mode_q != MODE_LEFT) begin
                state_d = ST_IDLE;
              end else begin
                state_d = ST_SCAN;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        // stall the scan while a pending result cannot move to the output
        if (!scan_stall) begin
          if (rv_q && hit) begin
            if (pend_q) begin
              ov_d      = 1'b1;
              ov_item_d = pend_item_q;
            end
            pend_d = 1'b1;
            any_d  = 1'b1;
            pend_item_d.build_row     = tbl_row;
            pend_item_d.build_present = 1'b1;
            pend_item_d.probe_row     = probe_q ? rid_q : 32'd0;
            pend_item_d.probe_present = probe_q;
            pend_item_d.last_of_run   = 1'b0;
            pend_item_d.overflow_seen = ovf_q;
            if (probe_q && mode_q == MODE_LEFT) begin
              matched_d[ridx_q] = 1'b1;
            end
          end
          if (idx_q < count_q) begin
            rv_d   = 1'b1;
            ridx_d = idx_q[AW-1:0];
            idx_d  = idx_q + 1'b1;
          end else begin
            rv_d    = 1'b0;
            state_d = ST_LAST;
          end
        end
      end
      ST_LAST: begin
        if (out_free) begin
          state_d = ST_IDLE;
          if (pend_q) begin
            ov_d      = 1'b1;
            ov_item_d = pend_item_q;
            ov_item_d.last_of_run = 1'b1;
            pend_d    = 1'b0;
          end else if (!any_q && probe_q && mode_q == MODE_RIGHT) begin
            ov_d = 1'b1;
            ov_item_d.build_row     = 32'd0;
            ov_item_d.build_present = 1'b0;
            ov_item_d.probe_row     = rid_q;
            ov_item_d.probe_present = 1'b1;
            ov_item_d.last_of_run   = 1'b1;
            ov_item_d.overflow_seen = ovf_q;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      mode_q    <= MODE_INNER;
      matched_q <= '0;
      rv_q      <= 1'b0;
      pend_q    <= 1'b0;
      ov_q      <= 1'b0;
      any_q     <= 1'b0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      matched_q <= matched_d;
      rv_q      <= rv_d;
      pend_q    <= pend_d;
      ov_q      <= ov_d;
      any_q     <= any_d;
      idx_q     <= idx_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    probe_q     <= probe_d;
    key_q       <= key_d;
    knull_q     <= knull_d;
    rid_q       <= rid_d;
    ridx_q      <= ridx_d;
    pend_item_q <= pend_item_d;
    ov_item_q   <= ov_item_d;
  end

  assign out_valid_o = ov_q;
  assign out_item_o  = ov_item_q;

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH)) else $error("entry count above depth");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_ready_o) else $error("ready while scanning");
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_q) else $error("result left pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(ov_item_q)) else $error("output lost");

endmodule
